// ----- design/ic3_pkg.sv -----
package ic3_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int COEF_FRAC_BITS = 12;
    localparam int COEF_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int WIDTH_W        = 12;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_INDEX_W    = 3;
    localparam int KERNEL_TAPS    = 3;

    // one line bank holds a full row of interleaved rgb bytes
    localparam int LINE_BYTES = 3 * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_BYTES);
    localparam int COL_W      = $clog2(LINE_BYTES + 1);

    localparam int WIN_COLS = 7;
    localparam int WIN_SIZE = KERNEL_TAPS * WIN_COLS;

    localparam int PROD_W = COEF_W + BYTE_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PIPE_STAGES = 3;
    localparam int FIFO_DEPTH  = 32;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W       = $clog2(FIFO_DEPTH + (PIPE_STAGES + 1) * MAX_RESULTS + 1);

    localparam logic [WIDTH_W-1:0]    LINE_WIDTH_RESET   = WIDTH_W'(2048);
    localparam logic [CFG_DATA_W-1:0] KERNEL_ROW_0_RESET = '0;
    localparam logic [CFG_DATA_W-1:0] KERNEL_ROW_1_RESET = CFG_DATA_W'(64'h0000_1000_0000);
    localparam logic [CFG_DATA_W-1:0] KERNEL_ROW_2_RESET = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH   = 3'd0,
        REG_COLOR_MODE   = 3'd1,
        REG_KERNEL_ROW_0 = 3'd2,
        REG_KERNEL_ROW_1 = 3'd3,
        REG_KERNEL_ROW_2 = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_out;
        logic              last_of_run;
        logic              frame_done;
    } result_t;

endpackage

// ----- design/ic3_if.sv -----
interface ic3_in_if import ic3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] sample;
    logic              frame_start;

    modport source (output valid, output kind, output sample, output frame_start,
                    input ready);
    modport sink   (input valid, input kind, input sample, input frame_start,
                    output ready);
endinterface

interface ic3_out_if import ic3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_out;
    logic              last_of_run;
    logic              frame_done;

    modport source (output valid, output pixel_out, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input pixel_out, input last_of_run, input frame_done,
                    output ready);
endinterface

// ----- design/ic3_ram.sv -----
module ic3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a same-address write shows up on the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/image_convolution_3x3_core.sv -----
// 3x3 convolution over a raster byte stream, grayscale or interleaved rgb.
// samples: one component byte per transfer; kind selects a pixel byte or a
//   drain request, frame_start clears the row, column and drain counters.
// results: filtered or copied bytes in raster order, running one row and
//   one pixel behind the input; last_of_run marks the last byte caused by an
//   input transfer, frame_done the last byte of the final row during drain.
// cfg_write/cfg_index/cfg_data: register writes, only while the block is idle.
// One input transfer per cycle is sustained while ready stays high. An item reads
// both line banks in the cycle it is taken; its results then pass the window
// and multipliers, the row sums, and the final sum and clamp before they are
// written into the output queue.
// A row end can cause up to four results; a 32-entry output queue absorbs
// them and ready drops only when the queue cannot hold the results of the
// items still in the pipeline. A stalled receiver therefore backs up into
// the queue and then into ready, nothing is dropped.
// Reset restores the register defaults (width 2048, grayscale, identity
// kernel) and clears the counters and window; the line banks need no
// clearing pass and the block accepts items right after reset.
module image_convolution_3x3_core
    import ic3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ic3_in_if.sink                 samples,
    ic3_out_if.source              results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MID_END = 2 * WIN_COLS - 1;
    localparam int TOP_END = WIN_COLS - 1;
    localparam int BOT_END = WIN_SIZE - 1;

    // configuration
    logic [WIDTH_W-1:0]    line_width_reg;
    logic                  color_mode_reg;
    logic [CFG_DATA_W-1:0] kernel_reg [KERNEL_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            color_mode_reg <= 1'b0;
            kernel_reg[0]  <= KERNEL_ROW_0_RESET;
            kernel_reg[1]  <= KERNEL_ROW_1_RESET;
            kernel_reg[2]  <= KERNEL_ROW_2_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LINE_WIDTH:   line_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_COLOR_MODE:   color_mode_reg <= cfg_data[0];
                REG_KERNEL_ROW_0: kernel_reg[0]  <= cfg_data;
                REG_KERNEL_ROW_1: kernel_reg[1]  <= cfg_data;
                REG_KERNEL_ROW_2: kernel_reg[2]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] coef [KERNEL_TAPS][KERNEL_TAPS];
    logic [COL_W-1:0]         width_eff;
    logic [COL_W-1:0]         row_len;
    logic [COL_W-1:0]         colors;

    always_comb
    begin
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            for (int l = 0; l < KERNEL_TAPS; l++)
            begin
                coef[k][l] = $signed(kernel_reg[k][COEF_W*l +: COEF_W]);
            end
        end
        if (line_width_reg == '0)
        begin
            width_eff = COL_W'(1);
        end
        else if (COL_W'(line_width_reg) > COL_W'(MAX_WIDTH))
        begin
            width_eff = COL_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = COL_W'(line_width_reg);
        end
        colors  = color_mode_reg ? COL_W'(3) : COL_W'(1);
        row_len = color_mode_reg ? COL_W'(width_eff + (width_eff << 1)) : width_eff;
    end

    // input stage: counters, line bank access and result decode
    logic [1:0]       phase_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] drain_reg;

    logic             accept;
    logic             is_drain;
    logic [1:0]       phase_eff;
    logic [COL_W-1:0] col_eff;
    logic [COL_W-1:0] drain_eff;
    logic [COL_W-1:0] col_pix;
    logic             row_end;
    logic [1:0]       phase_next;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] drain_next;
    logic             started;
    logic             drain_ok;
    logic             first_res;
    logic             border;
    logic [1:0]       border_cnt;
    logic             use_filt;
    logic [CNT_W-1:0] res_cnt;
    logic             bank_sel;
    logic [LINE_AW-1:0] ram_raddr;
    logic             we0;
    logic             we1;

    always_comb
    begin
        accept    = samples.valid && samples.ready;
        is_drain  = (item_kind_t'(samples.kind) == KIND_DRAIN);
        phase_eff = samples.frame_start ? 2'd0 : phase_reg;
        col_eff   = samples.frame_start ? '0 : col_reg;
        drain_eff = samples.frame_start ? '0 : drain_reg;
        col_pix   = (col_eff >= row_len) ? '0 : col_eff;
        row_end   = (col_pix + 1'b1) >= row_len;
        started   = (phase_eff != 2'd0);

        phase_next = phase_eff;
        col_next   = col_eff;
        drain_next = drain_eff;

        drain_ok  = started && (drain_eff < row_len);
        first_res = started && (col_pix >= colors);
        border    = started && (col_pix == row_len - 1'b1);
        use_filt  = first_res && phase_eff[1] && (col_pix >= (colors << 1));
        if (!border)
        begin
            border_cnt = 2'd0;
        end
        else if (col_pix >= colors)
        begin
            border_cnt = 2'(colors);
        end
        else
        begin
            border_cnt = 2'(col_pix + 1'b1);
        end

        if (is_drain)
        begin
            res_cnt  = drain_ok ? CNT_W'(1) : '0;
            bank_sel = ~phase_eff[0];
            if (drain_ok)
            begin
                drain_next = drain_eff + 1'b1;
            end
        end
        else
        begin
            res_cnt  = CNT_W'(first_res) + CNT_W'(border_cnt);
            bank_sel = phase_eff[0];
            if (row_end)
            begin
                col_next   = '0;
                phase_next = (phase_eff == 2'd3) ? 2'd2 : phase_eff + 2'd1;
            end
            else
            begin
                col_next = col_pix + 1'b1;
            end
        end

        ram_raddr = is_drain ? drain_eff[LINE_AW-1:0] : col_pix[LINE_AW-1:0];
        we0       = accept && !is_drain && !phase_eff[0];
        we1       = accept && !is_drain && phase_eff[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            col_reg   <= '0;
            drain_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    logic [BYTE_W-1:0] rd0;
    logic [BYTE_W-1:0] rd1;

    ic3_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (col_pix[LINE_AW-1:0]),
        .wdata (samples.sample),
        .raddr (ram_raddr),
        .rdata (rd0)
    );

    ic3_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (col_pix[LINE_AW-1:0]),
        .wdata (samples.sample),
        .raddr (ram_raddr),
        .rdata (rd1)
    );

    // stage a: bank data arrives, window shift and multipliers
    logic              a_valid_reg;
    logic              a_drain_reg;
    logic [BYTE_W-1:0] a_sample_reg;
    logic              a_bank_reg;
    logic              a_first_reg;
    logic [1:0]        a_border_reg;
    logic              a_filt_reg;
    logic [CNT_W-1:0]  a_cnt_reg;
    logic              a_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_drain_reg  <= is_drain;
            a_sample_reg <= samples.sample;
            a_bank_reg   <= bank_sel;
            a_first_reg  <= first_res;
            a_border_reg <= border_cnt;
            a_filt_reg   <= use_filt;
            a_cnt_reg    <= res_cnt;
            a_done_reg   <= is_drain && (drain_eff == row_len - 1'b1);
        end
    end

    logic [BYTE_W-1:0] win_reg [WIN_SIZE];
    logic [BYTE_W-1:0] win_next [WIN_SIZE];
    logic [BYTE_W-1:0] bank_data;
    logic [BYTE_W-1:0] other_data;
    logic [BYTE_W-1:0] border_val [3];
    logic [BYTE_W-1:0] centre_val;
    logic [BYTE_W-1:0] a_vals [MAX_RESULTS];
    logic [BYTE_W-1:0] tap [KERNEL_TAPS][KERNEL_TAPS];
    logic signed [PROD_W-1:0] prod_next [KERNEL_TAPS][KERNEL_TAPS];

    always_comb
    begin
        bank_data  = a_bank_reg ? rd1 : rd0;
        other_data = a_bank_reg ? rd0 : rd1;

        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            for (int i = 0; i < WIN_COLS - 1; i++)
            begin
                win_next[k*WIN_COLS + i] = win_reg[k*WIN_COLS + i + 1];
            end
        end
        win_next[TOP_END] = bank_data;
        win_next[MID_END] = other_data;
        win_next[BOT_END] = a_sample_reg;

        // right border bytes of the previous row, oldest first
        case (a_border_reg)
            2'd1:
            begin
                border_val[0] = win_next[MID_END];
                border_val[1] = '0;
                border_val[2] = '0;
            end
            2'd2:
            begin
                border_val[0] = win_next[MID_END-1];
                border_val[1] = win_next[MID_END];
                border_val[2] = '0;
            end
            2'd3:
            begin
                border_val[0] = win_next[MID_END-2];
                border_val[1] = win_next[MID_END-1];
                border_val[2] = win_next[MID_END];
            end
            default:
            begin
                border_val[0] = '0;
                border_val[1] = '0;
                border_val[2] = '0;
            end
        endcase

        centre_val = color_mode_reg ? win_next[MID_END-3] : win_next[MID_END-1];

        if (a_drain_reg)
        begin
            a_vals[0] = bank_data;
            a_vals[1] = '0;
            a_vals[2] = '0;
            a_vals[3] = '0;
        end
        else if (a_first_reg)
        begin
            a_vals[0] = centre_val;
            a_vals[1] = border_val[0];
            a_vals[2] = border_val[1];
            a_vals[3] = border_val[2];
        end
        else
        begin
            a_vals[0] = border_val[0];
            a_vals[1] = border_val[1];
            a_vals[2] = border_val[2];
            a_vals[3] = '0;
        end

        // same-component neighbors sit one or three bytes apart
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            for (int l = 0; l < KERNEL_TAPS; l++)
            begin
                if (color_mode_reg)
                begin
                    tap[k][l] = win_next[k*WIN_COLS + WIN_COLS - 7 + 3*l];
                end
                else
                begin
                    tap[k][l] = win_next[k*WIN_COLS + WIN_COLS - 3 + l];
                end
                prod_next[k][l] = PROD_W'(coef[k][l]) * PROD_W'($signed({1'b0, tap[k][l]}));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_SIZE; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (a_valid_reg && !a_drain_reg)
        begin
            win_reg <= win_next;
        end
    end

    // stage b: products
    logic                     b_valid_reg;
    logic [CNT_W-1:0]         b_cnt_reg;
    logic                     b_filt_reg;
    logic                     b_done_reg;
    logic [BYTE_W-1:0]        b_vals_reg [MAX_RESULTS];
    logic signed [PROD_W-1:0] b_prod_reg [KERNEL_TAPS][KERNEL_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_cnt_reg  <= a_cnt_reg;
        b_filt_reg <= a_filt_reg && !a_drain_reg;
        b_done_reg <= a_done_reg;
        b_vals_reg <= a_vals;
        b_prod_reg <= prod_next;
    end

    // stage c: row sums
    logic                    c_valid_reg;
    logic [CNT_W-1:0]        c_cnt_reg;
    logic                    c_filt_reg;
    logic                    c_done_reg;
    logic [BYTE_W-1:0]       c_vals_reg [MAX_RESULTS];
    logic signed [SUM_W-1:0] c_row_reg [KERNEL_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_cnt_reg  <= b_cnt_reg;
        c_filt_reg <= b_filt_reg;
        c_done_reg <= b_done_reg;
        c_vals_reg <= b_vals_reg;
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            c_row_reg[k] <= SUM_W'(b_prod_reg[k][0]) + SUM_W'(b_prod_reg[k][1])
                          + SUM_W'(b_prod_reg[k][2]);
        end
    end

    // final sum, truncate toward zero, clamp, then into the output queue
    logic signed [SUM_W-1:0]           total;
    logic [SUM_W-2-COEF_FRAC_BITS:0]   quot;
    logic [BYTE_W-1:0]                 filt_byte;
    result_t                           push_entry [MAX_RESULTS];

    always_comb
    begin
        total = c_row_reg[0] + c_row_reg[1] + c_row_reg[2];
        quot  = total[SUM_W-2:COEF_FRAC_BITS];
        if (total <= 0)
        begin
            filt_byte = '0;
        end
        else if (quot > (SUM_W-1-COEF_FRAC_BITS)'({BYTE_W{1'b1}}))
        begin
            filt_byte = {BYTE_W{1'b1}};
        end
        else
        begin
            filt_byte = quot[BYTE_W-1:0];
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            push_entry[i].pixel_out   = (i == 0 && c_filt_reg) ? filt_byte : c_vals_reg[i];
            push_entry[i].last_of_run = (CNT_W'(i + 1) == c_cnt_reg);
            push_entry[i].frame_done  = (i == 0) && c_done_reg;
        end
    end

    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   fifo_count_reg;
    logic                 pop;
    logic [CNT_W-1:0]     push_cnt;
    logic [2:0]           pending;
    logic [RES_W-1:0]     reserve;

    always_comb
    begin
        push_cnt = c_valid_reg ? c_cnt_reg : '0;
        pop      = results.valid && results.ready;
        // every item in flight may still add a full run of results
        pending  = 3'(a_valid_reg) + 3'(b_valid_reg) + 3'(c_valid_reg) + 3'd1;
        reserve  = RES_W'(fifo_count_reg) + RES_W'(pending) * RES_W'(MAX_RESULTS);
    end

    assign samples.ready       = (reserve <= RES_W'(FIFO_DEPTH));
    assign results.valid       = (fifo_count_reg != '0);
    assign results.pixel_out   = fifo_mem[rd_ptr_reg].pixel_out;
    assign results.last_of_run = fifo_mem[rd_ptr_reg].last_of_run;
    assign results.frame_done  = fifo_mem[rd_ptr_reg].frame_done;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (CNT_W'(i) < push_cnt)
            begin
                fifo_mem[FIFO_AW'(wr_ptr_reg + FIFO_AW'(i))] <= push_entry[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= FIFO_AW'(wr_ptr_reg + FIFO_AW'(push_cnt));
            rd_ptr_reg     <= FIFO_AW'(rd_ptr_reg + FIFO_AW'(pop));
            fifo_count_reg <= FIFO_CW'(fifo_count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop));
        end
    end

endmodule
